>>> hdl/led_matrix_scan_driver_defines.svh
// led_matrix_scan_driver_defines.svh: assertion macros for the led panel scan driver
// no dependencies; included by the modules that carry assertions
`ifndef LED_MATRIX_SCAN_DRIVER_DEFINES_SVH
`define LED_MATRIX_SCAN_DRIVER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LMSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define LMSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/lmsd_pkg.sv
// lmsd_pkg: shared types and constants of the led panel scan driver
// no dependencies; used by lmsd_frame_store and led_matrix_scan_driver
package lmsd_pkg;

  // default panel geometry
  localparam int PANEL_COLUMNS_DEF = 32;
  localparam int PANEL_ROWS_DEF    = 16;

  // item field widths
  localparam int X_W     = 5;
  localparam int Y_W     = 4;
  localparam int COLOR_W = 3;
  localparam int ROWADR_W = 3;
  localparam int DWELL_W = 16;

  // dwell register reset value
  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd500;

  // action codes
  localparam logic ACTION_FILL = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  // frame store sequencer modes
  typedef enum logic [1:0] {
    MODE_CLEAR,
    MODE_IDLE,
    MODE_WALK
  } store_mode_t;

endpackage

>>> hdl/lmsd_frame_store.sv
// lmsd_frame_store: frame store memory with clearing pass, rectangle fill walker
// and scan read port; depends on lmsd_pkg and led_matrix_scan_driver_defines.svh
`include "led_matrix_scan_driver_defines.svh"

module lmsd_frame_store #(
  parameter int PANEL_COLUMNS = lmsd_pkg::PANEL_COLUMNS_DEF,
  parameter int PANEL_ROWS    = lmsd_pkg::PANEL_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fill_start,
  input  logic [lmsd_pkg::X_W-1:0]          x_first,
  input  logic [lmsd_pkg::Y_W-1:0]          y_first,
  input  logic [lmsd_pkg::X_W-1:0]          x_second,
  input  logic [lmsd_pkg::Y_W-1:0]          y_second,
  input  logic [lmsd_pkg::COLOR_W-1:0]      fill_color,
  input  logic                              scan_rd_en,
  input  logic [$clog2(PANEL_COLUMNS)-1:0]  scan_col,
  input  logic [((PANEL_ROWS/2) > 1 ? $clog2(PANEL_ROWS/2) : 1)-1:0] scan_pair,
  output logic [lmsd_pkg::COLOR_W-1:0]      scan_top,
  output logic [lmsd_pkg::COLOR_W-1:0]      scan_bottom,
  output logic                              busy
);

  localparam int ROW_PAIRS = PANEL_ROWS / 2;
  localparam int ENTRIES   = PANEL_COLUMNS * ROW_PAIRS;
  localparam int ADDR_W    = $clog2(ENTRIES);
  localparam int COL_W     = $clog2(PANEL_COLUMNS);
  localparam int ROW_W     = $clog2(PANEL_ROWS);
  localparam int PAIR_W    = (ROW_PAIRS > 1) ? $clog2(ROW_PAIRS) : 1;
  localparam int CW        = lmsd_pkg::COLOR_W;

  // one entry holds a column of a row pair: top pixel low, bottom pixel high
  logic [2*CW-1:0] mem [ENTRIES];

  lmsd_pkg::store_mode_t mode, mode_next;

  logic [ADDR_W-1:0] clr_addr;
  logic [COL_W-1:0]  wx, x_hi;
  logic [ROW_W-1:0]  wy, y_lo, y_hi;
  logic [CW-1:0]     color;

  // corner clamping and ordering at fill start
  logic [COL_W-1:0] xa, xb;
  logic [ROW_W-1:0] ya, yb;

  assign xa = (32'(x_first) >= PANEL_COLUMNS) ? COL_W'(PANEL_COLUMNS - 1) : COL_W'(x_first);
  assign xb = (32'(x_second) >= PANEL_COLUMNS) ? COL_W'(PANEL_COLUMNS - 1) : COL_W'(x_second);
  assign ya = (32'(y_first) >= PANEL_ROWS) ? ROW_W'(PANEL_ROWS - 1) : ROW_W'(y_first);
  assign yb = (32'(y_second) >= PANEL_ROWS) ? ROW_W'(PANEL_ROWS - 1) : ROW_W'(y_second);

  // walker pixel to entry address and half
  logic              walk_half;
  logic [PAIR_W-1:0] walk_pair;
  logic [ADDR_W-1:0] walk_addr;
  logic              walk_last;

  assign walk_half = (32'(wy) >= ROW_PAIRS);
  assign walk_pair = walk_half ? PAIR_W'(32'(wy) - ROW_PAIRS) : PAIR_W'(wy);
  assign walk_addr = ADDR_W'(ADDR_W'(wx) * ADDR_W'(ROW_PAIRS) + ADDR_W'(walk_pair));
  assign walk_last = (wx == x_hi) && (wy == y_hi);

  // sequencer next mode
  always_comb begin
    mode_next = mode;
    case (mode)
      lmsd_pkg::MODE_CLEAR: begin
        if (clr_addr == ADDR_W'(ENTRIES - 1)) mode_next = lmsd_pkg::MODE_IDLE;
      end
      lmsd_pkg::MODE_IDLE: begin
        if (fill_start) mode_next = lmsd_pkg::MODE_WALK;
      end
      lmsd_pkg::MODE_WALK: begin
        if (walk_last) mode_next = lmsd_pkg::MODE_IDLE;
      end
      default: mode_next = lmsd_pkg::MODE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= lmsd_pkg::MODE_CLEAR;
    end else begin
      mode <= mode_next;
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (mode == lmsd_pkg::MODE_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // walker position, column outer, row inner
  always_ff @(posedge clk) begin
    if (mode == lmsd_pkg::MODE_IDLE && fill_start) begin
      wx    <= (xa < xb) ? xa : xb;
      x_hi  <= (xa < xb) ? xb : xa;
      wy    <= (ya < yb) ? ya : yb;
      y_lo  <= (ya < yb) ? ya : yb;
      y_hi  <= (ya < yb) ? yb : ya;
      color <= fill_color;
    end else if (mode == lmsd_pkg::MODE_WALK) begin
      if (wy == y_hi) begin
        wy <= y_lo;
        wx <= wx + 1'b1;
      end else begin
        wy <= wy + 1'b1;
      end
    end
  end

  // write-back stage with forwarding of the entry just written
  logic              wr_valid, wr_half, fwd_hit;
  logic [ADDR_W-1:0] wr_addr;
  logic [CW-1:0]     wr_color;
  logic [2*CW-1:0]   fill_rd_data, fwd_data, old_entry, merged;

  assign old_entry = fwd_hit ? fwd_data : fill_rd_data;
  assign merged    = wr_half ? {wr_color, old_entry[CW-1:0]}
                             : {old_entry[2*CW-1:CW], wr_color};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      wr_valid <= (mode == lmsd_pkg::MODE_WALK);
      fwd_hit  <= (mode == lmsd_pkg::MODE_WALK) && wr_valid && (walk_addr == wr_addr);
    end
  end

  always_ff @(posedge clk) begin
    wr_addr  <= walk_addr;
    wr_half  <= walk_half;
    wr_color <= color;
    fwd_data <= merged;
  end

  // memory write port mux
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [2*CW-1:0]   mem_wdata;

  assign mem_we    = (mode == lmsd_pkg::MODE_CLEAR) || wr_valid;
  assign mem_waddr = (mode == lmsd_pkg::MODE_CLEAR) ? clr_addr : wr_addr;
  assign mem_wdata = (mode == lmsd_pkg::MODE_CLEAR) ? '0 : merged;

  // scan read address
  logic [ADDR_W-1:0] scan_addr;
  logic [2*CW-1:0]   scan_rd_data;

  assign scan_addr = ADDR_W'(ADDR_W'(scan_col) * ADDR_W'(ROW_PAIRS) + ADDR_W'(scan_pair));

  // memory: one write port, fill and scan read ports, registered reads
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mode == lmsd_pkg::MODE_WALK) fill_rd_data <= mem[walk_addr];
    if (scan_rd_en) scan_rd_data <= mem[scan_addr];
  end

  assign scan_top    = scan_rd_data[CW-1:0];
  assign scan_bottom = scan_rd_data[2*CW-1:CW];
  assign busy        = (mode != lmsd_pkg::MODE_IDLE) || wr_valid;

  // checks
  `LMSD_ASSERT_NOW(a_start_idle, fill_start, !busy, "fill started while store busy")
  `LMSD_ASSERT_NOW(a_walk_bounds, mode == lmsd_pkg::MODE_WALK,
    (wx <= x_hi) && (wy >= y_lo) && (wy <= y_hi), "fill walker outside rectangle")
  `LMSD_ASSERT_NOW(a_scan_quiet, scan_rd_en, !busy && !mem_we, "scan read during store update")

endmodule

>>> hdl/led_matrix_scan_driver.sv
// Scan driver for an RGB LED panel (32x16, 1/8 scan by default) fed from a 3-bit frame
// store. A tick item gives one item of pin levels through the scan read stage and the
// output register; ticks are taken one per cycle while the result side keeps up and no
// fill is in progress; the output register and the scan read stage let a new tick enter
// while a finished item waits. A fill item gives no result and holds the input until the
// frame store is done: the fill walks the rectangle one pixel a cycle through a
// read-modify-write on the frame store, which keeps a row pair's top and bottom pixel in
// one entry. After reset the store clears its PANEL_COLUMNS * PANEL_ROWS / 2 entries
// (256 by default) before the first item is taken; dwell_ticks writes are taken at any time.
// depends on lmsd_pkg, lmsd_frame_store and led_matrix_scan_driver_defines.svh
`include "led_matrix_scan_driver_defines.svh"

module led_matrix_scan_driver #(
  parameter int PANEL_COLUMNS = lmsd_pkg::PANEL_COLUMNS_DEF,
  parameter int PANEL_ROWS    = lmsd_pkg::PANEL_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lmsd_pkg::DWELL_W-1:0]      cfg_data,
  // input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [lmsd_pkg::X_W-1:0]          x_first,
  input  logic [lmsd_pkg::Y_W-1:0]          y_first,
  input  logic [lmsd_pkg::X_W-1:0]          x_second,
  input  logic [lmsd_pkg::Y_W-1:0]          y_second,
  input  logic [lmsd_pkg::COLOR_W-1:0]      fill_color,
  // result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lmsd_pkg::ROWADR_W-1:0]     row_address,
  output logic [lmsd_pkg::COLOR_W-1:0]      top_rgb,
  output logic [lmsd_pkg::COLOR_W-1:0]      bottom_rgb,
  output logic                              shift_pulse,
  output logic                              latch_pulse,
  output logic                              blank
);

  localparam int ROW_PAIRS = PANEL_ROWS / 2;
  localparam int COL_W     = $clog2(PANEL_COLUMNS);
  localparam int PAIR_W    = (ROW_PAIRS > 1) ? $clog2(ROW_PAIRS) : 1;
  localparam int DW        = lmsd_pkg::DWELL_W;
  localparam int CW        = lmsd_pkg::COLOR_W;

  // dwell register
  logic [DW-1:0] dwell_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_ticks <= lmsd_pkg::DWELL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dwell_ticks <= cfg_data;
    end
  end

  // handshake and pipeline flow
  logic store_busy;
  logic s1_valid, s1_adv;
  logic tick_accept, fill_accept;

  assign s1_adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready    = !store_busy && (!s1_valid || s1_adv);
  assign tick_accept = in_valid && in_ready && (action == lmsd_pkg::ACTION_TICK);
  assign fill_accept = in_valid && in_ready && (action == lmsd_pkg::ACTION_FILL);

  // scan position
  logic [PAIR_W-1:0] scan_row, scan_row_next, row_wrap;
  logic [COL_W-1:0]  scan_column, scan_column_next;
  logic [DW-1:0]     dwell_count, dwell_count_next, dwell_dec;
  logic              in_dwell, in_dwell_next;
  logic              tick_shift, tick_latch, tick_blank;

  assign dwell_dec = (dwell_count != '0) ? dwell_count - 1'b1 : '0;
  assign row_wrap  = (scan_row == PAIR_W'(ROW_PAIRS - 1)) ? '0 : scan_row + 1'b1;

  // scan step for one tick
  always_comb begin
    scan_row_next    = scan_row;
    scan_column_next = scan_column;
    dwell_count_next = dwell_count;
    in_dwell_next    = in_dwell;
    tick_shift       = 1'b0;
    tick_latch       = 1'b0;
    tick_blank       = 1'b0;
    if (in_dwell) begin
      dwell_count_next = dwell_dec;
      if (dwell_dec == '0) begin
        in_dwell_next    = 1'b0;
        scan_column_next = '0;
        scan_row_next    = row_wrap;
      end
    end else begin
      tick_shift = 1'b1;
      tick_blank = 1'b1;
      if (scan_column == COL_W'(PANEL_COLUMNS - 1)) begin
        tick_latch = 1'b1;
        if (dwell_ticks == '0) begin
          scan_column_next = '0;
          scan_row_next    = row_wrap;
        end else begin
          in_dwell_next    = 1'b1;
          dwell_count_next = dwell_ticks;
        end
      end else begin
        scan_column_next = scan_column + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row    <= '0;
      scan_column <= '0;
      dwell_count <= '0;
      in_dwell    <= 1'b0;
    end else if (tick_accept) begin
      scan_row    <= scan_row_next;
      scan_column <= scan_column_next;
      dwell_count <= dwell_count_next;
      in_dwell    <= in_dwell_next;
    end
  end

  // frame store
  logic [CW-1:0] scan_top, scan_bottom;

  lmsd_frame_store #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .PANEL_ROWS    (PANEL_ROWS)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .fill_start  (fill_accept),
    .x_first     (x_first),
    .y_first     (y_first),
    .x_second    (x_second),
    .y_second    (y_second),
    .fill_color  (fill_color),
    .scan_rd_en  (tick_accept && !in_dwell),
    .scan_col    (scan_column),
    .scan_pair   (scan_row),
    .scan_top    (scan_top),
    .scan_bottom (scan_bottom),
    .busy        (store_busy)
  );

  // read stage: pin levels wait for the pixel read
  localparam int ROWADR_W_T = lmsd_pkg::ROWADR_W;

  logic [31:0]         row_ext;
  logic [ROWADR_W_T-1:0] s1_row;
  logic                s1_shift, s1_latch, s1_blank;

  assign row_ext = 32'(scan_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      s1_row   <= row_ext[ROWADR_W_T-1:0];
      s1_shift <= tick_shift;
      s1_latch <= tick_latch;
      s1_blank <= tick_blank;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      row_address <= s1_row;
      top_rgb     <= s1_shift ? scan_top : '0;
      bottom_rgb  <= s1_shift ? scan_bottom : '0;
      shift_pulse <= s1_shift;
      latch_pulse <= s1_latch;
      blank       <= s1_blank;
    end
  end

  // checks
  `LMSD_ASSERT_NOW(a_dwell_live, in_dwell, dwell_count != '0, "dwell phase with zero count")
  `LMSD_ASSERT_NOW(a_scan_range, 1'b1,
    (32'(scan_column) < PANEL_COLUMNS) && (32'(scan_row) < ROW_PAIRS), "scan position out of range")
  `LMSD_ASSERT_NOW(a_latch_shift, out_valid && latch_pulse, shift_pulse && blank,
    "latch without shift while dark")
  `LMSD_ASSERT_NEXT(a_latch_turn, tick_accept && tick_latch && (dwell_ticks != '0),
    in_dwell && (scan_column == COL_W'(PANEL_COLUMNS - 1)), "latch did not enter dwell")

endmodule
